// File: sv/mprs_pkg.sv
package mprs_pkg;

	typedef struct packed {
		logic [63:0] node_w0;
		logic [63:0] node_w1;
		logic [63:0] node_w2;
		logic [63:0] node_w3;
		logic        is_leaf;
		logic        comp_is_right;
		logic        last_in_path;
	} in_item_t;

	typedef struct packed {
		logic [63:0] root_w0;
		logic [63:0] root_w1;
		logic [63:0] root_w2;
		logic [63:0] root_w3;
	} out_item_t;

	// message length of two 32-byte nodes, in bits
	localparam logic [31:0] MSG_BITS = 32'd512;
	localparam logic [31:0] PAD_WORD = 32'h8000_0000;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			unique case (i)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
				6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
				6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
				6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
				6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
				6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
				6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
				6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
				6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
				6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
				6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
				default: k = 32'hc67178f2;
			endcase
			return k;
		end
	endfunction

	function automatic logic [255:0] init_state();
		return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	endfunction

	// node words (byte 0 in bits 7:0) to eight big-endian message words, word 0 on top
	function automatic logic [255:0] node_to_msg(input logic [255:0] n);
		logic [255:0] m;
		begin
			for (int b = 0; b < 32; b++)
				m[255 - 8*b -: 8] = n[8*b +: 8];
			return m;
		end
	endfunction

endpackage

// File: sv/merkle_path_root_sha256_core.sv
// Channel | Direction | Handshake           | Payload
// in      | into core | in_valid / in_stall | in_data  (in_item_t)
// out     | from core | out_valid/ out_stall| out_data (out_item_t)
//
// A sibling that needs hashing passes through the accept cycle, two SHA-256
// compressions of 64 rounds each on one shared round unit, one finalize step
// per block and the emit state. Leaf, zero-node and pass-through items finish at accept.
// in_stall stays high while a hash runs or a root waits to be taken.
// arst_n clears the running node to zeros and empties the output register.
module merkle_path_root_sha256_core
	import mprs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RND  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t        state_q;
	logic [255:0]  node_q;     // running node, byte 0 in bits 7:0
	logic [255:0]  hst_q;      // chaining state a..h, a on top
	logic [255:0]  wrk_q;      // working variables a..h
	logic [511:0]  wnd_q;      // message schedule window, w[t] on top
	logic [5:0]    rnd_q;
	logic          blk_q;      // 0: data block, 1: padding block
	logic          last_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic          take;
	logic [255:0]  sib;
	logic          sib_zero, node_zero;
	logic [255:0]  left_n, right_n;

	assign in_stall  = (state_q != ST_IDLE) || out_valid_q;
	assign take      = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign sib       = {in_data.node_w3, in_data.node_w2, in_data.node_w1, in_data.node_w0};
	assign sib_zero  = (sib == '0);
	assign node_zero = (node_q == '0);
	assign left_n    = in_data.comp_is_right ? node_q : sib;
	assign right_n   = in_data.comp_is_right ? sib : node_q;

	// shared round unit
	logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt, w1, w14, w9, s0, s1, wnew;
	always_comb begin
		{a, b, c, d, e, f, g, h} = wrk_q;
		wt   = wnd_q[511 -: 32];
		w1   = wnd_q[479 -: 32];
		w9   = wnd_q[223 -: 32];
		w14  = wnd_q[63 -: 32];
		t1   = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & f) ^ (~e & g)) + round_k(rnd_q) + wt;
		t2   = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & b) ^ (a & c) ^ (b & c));
		s0   = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
		s1   = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
		wnew = wt + s0 + w9 + s1;
	end

	// finalize: chaining add, then back to node byte order
	logic [255:0] hsum;
	logic [255:0] hout;
	always_comb begin
		for (int i = 0; i < 8; i++)
			hsum[32*i +: 32] = hst_q[32*i +: 32] + wrk_q[32*i +: 32];
		for (int bi = 0; bi < 32; bi++)
			hout[8*bi +: 8] = hsum[255 - 8*bi -: 8];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			node_q      <= '0;
			out_valid_q <= 1'b0;
			rnd_q       <= '0;
			blk_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						last_q <= in_data.last_in_path;
						if (in_data.is_leaf || (!sib_zero && node_zero)) begin
							node_q <= sib;
							out_q  <= '{sib[63:0], sib[127:64], sib[191:128], sib[255:192]};
							if (in_data.last_in_path)
								out_valid_q <= 1'b1;
						end else if (sib_zero) begin
							out_q <= '{node_q[63:0], node_q[127:64], node_q[191:128],
								node_q[255:192]};
							if (in_data.last_in_path)
								out_valid_q <= 1'b1;
						end else begin
							hst_q   <= init_state();
							wrk_q   <= init_state();
							wnd_q   <= {node_to_msg(left_n), node_to_msg(right_n)};
							rnd_q   <= '0;
							blk_q   <= 1'b0;
							state_q <= ST_RND;
						end
					end
				end
				ST_RND: begin
					wrk_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
					wnd_q <= {wnd_q[479:0], wnew};
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!blk_q) begin
						hst_q   <= hsum;
						wrk_q   <= hsum;
						wnd_q   <= {PAD_WORD, 448'd0, MSG_BITS};
						blk_q   <= 1'b1;
						state_q <= ST_RND;
					end else begin
						node_q  <= hout;
						out_q   <= '{hout[63:0], hout[127:64], hout[191:128], hout[255:192]};
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (last_q)
						out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sim/merkle_path_root_sha256_core_tb.sv
module merkle_path_root_sha256_core_tb
	import mprs_pkg::*;
();

	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_RANDOM = 1250;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	merkle_path_root_sha256_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// round constants for the predictor
	logic [31:0] sha_k [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	in_item_t  pending_items[$];
	out_item_t expected_roots[$];
	logic [63:0] path_node [4];
	int errors;
	int cycles;
	bit stim_done;
	bit hold_off;

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one SHA-256 compression, state words 0..7 in st
	function automatic void sha_compress(ref logic [31:0] st[8], input logic [31:0] blk[16]);
		logic [31:0] w[64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = st[0]; b = st[1]; c = st[2]; d = st[3];
		e = st[4]; f = st[5]; g = st[6]; h = st[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ sha_k[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		st[0] += a; st[1] += b; st[2] += c; st[3] += d;
		st[4] += e; st[5] += f; st[6] += g; st[7] += h;
	endfunction

	// SHA-256 of left || right, nodes as four little-endian 64-bit words
	function automatic void hash_nodes(input logic [63:0] lft[4], input logic [63:0] rgt[4],
			output logic [63:0] res[4]);
		logic [31:0] st[8];
		logic [31:0] blk[16];
		logic [7:0] bt;
		int bi;
		st = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		for (int i = 0; i < 16; i++) begin
			blk[i] = '0;
			for (int k = 0; k < 4; k++) begin
				bi = (i % 8) * 4 + k;
				bt = (i < 8) ? lft[bi / 8][(bi % 8) * 8 +: 8] : rgt[bi / 8][(bi % 8) * 8 +: 8];
				blk[i] = (blk[i] << 8) | {24'd0, bt};
			end
		end
		sha_compress(st, blk);
		for (int i = 0; i < 16; i++) blk[i] = '0;
		blk[0] = 32'h8000_0000;
		blk[15] = 32'd512;
		sha_compress(st, blk);
		for (int i = 0; i < 4; i++) begin
			res[i] = '0;
			for (int k = 0; k < 8; k++) begin
				bi = i * 8 + k;
				res[i][k*8 +: 8] = st[bi / 4][(3 - bi % 4) * 8 +: 8];
			end
		end
	endfunction

	// advance the path node by one item, queue the root on a last item
	function automatic void predict_path(in_item_t it);
		logic [63:0] sib[4];
		logic [63:0] res[4];
		out_item_t r;
		sib = '{it.node_w0, it.node_w1, it.node_w2, it.node_w3};
		if (it.is_leaf) begin
			path_node = sib;
		end else if ((sib[0] | sib[1] | sib[2] | sib[3]) == '0) begin
		end else if ((path_node[0] | path_node[1] | path_node[2] | path_node[3]) == '0) begin
			path_node = sib;
		end else begin
			if (it.comp_is_right) hash_nodes(path_node, sib, res);
			else hash_nodes(sib, path_node, res);
			path_node = res;
		end
		if (it.last_in_path) begin
			r.root_w0 = path_node[0]; r.root_w1 = path_node[1];
			r.root_w2 = path_node[2]; r.root_w3 = path_node[3];
			expected_roots.push_back(r);
		end
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_item_t make_item(logic [63:0] w, bit leaf, bit right, bit last);
		in_item_t it;
		it.node_w0 = w; it.node_w1 = ~w; it.node_w2 = {w[31:0], w[63:32]}; it.node_w3 = w ^ 64'h5a;
		it.is_leaf = leaf; it.comp_is_right = right; it.last_in_path = last;
		return it;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus: directed cases, then mostly well-formed paths
	initial begin
		in_item_t it;
		int n, depth;
		for (int i = 0; i < 4; i++) path_node[i] = '0;
		it = '0;
		pending_items.push_back(make_item(64'h1, 1'b0, 1'b1, 1'b1)); // sibling before any leaf
		it.last_in_path = 1'b1;
		pending_items.push_back(it);                              // zero sibling keeps node
		pending_items.push_back(make_item('1, 1'b0, 1'b0, 1'b0));
		pending_items.push_back(make_item(64'h0123456789abcdef, 1'b0, 1'b1, 1'b1));
		it = '0; it.is_leaf = 1'b1; it.last_in_path = 1'b1;
		pending_items.push_back(it);                              // zero leaf
		pending_items.push_back(make_item(64'hfedcba9876543210, 1'b0, 1'b0, 1'b1)); // takes sibling
		pending_items.push_back(make_item('1, 1'b1, 1'b1, 1'b1));  // leaf last
		pending_items.push_back(make_item(64'h0, 1'b1, 1'b0, 1'b0));
		pending_items.push_back(make_item(64'h8000000000000000, 1'b0, 1'b0, 1'b0));
		pending_items.push_back(make_item(64'h55aa55aa55aa55aa, 1'b0, 1'b1, 1'b1));
		pending_items.push_back(make_item(64'h3, 1'b0, 1'b0, 1'b1)); // continue after last
		it = '0; it.node_w0 = '1; it.node_w1 = '1; it.node_w2 = '1; it.node_w3 = '1;
		it.comp_is_right = 1'b1; it.last_in_path = 1'b1;
		pending_items.push_back(it);
		n = pending_items.size();
		while (n < N_RANDOM) begin
			if ($urandom_range(0, 9) == 0) begin
				it.node_w0 = rand_word(); it.node_w1 = rand_word();
				it.node_w2 = rand_word(); it.node_w3 = rand_word();
				it.is_leaf = 1'($urandom);
				it.comp_is_right = 1'($urandom);
				it.last_in_path = 1'($urandom);
				pending_items.push_back(it);
				n++;
			end else begin
				depth = $urandom_range(0, 5);
				for (int d = 0; d <= depth; d++) begin
					it.node_w0 = rand_word(); it.node_w1 = {$urandom, $urandom};
					it.node_w2 = {$urandom, $urandom}; it.node_w3 = {$urandom, $urandom};
					if ($urandom_range(0, 15) == 0)
						it = make_item(64'd0, 1'b0, 1'b0, 1'b0);
					it.is_leaf = (d == 0);
					it.comp_is_right = 1'($urandom);
					it.last_in_path = (d == depth);
					pending_items.push_back(it);
					n++;
				end
			end
		end
	end

	// driver: bursts with random gaps, one pause until the block drains
	int burst_left, gap_left, sent;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
			sent <= 0;
			stim_done <= 1'b0;
			hold_off <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_path(in_data);
				sent <= sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (in_valid && !in_stall && sent + 1 == 600) begin
					hold_off <= 1'b1;
					in_valid <= 1'b0;
				end else if (hold_off) begin
					in_valid <= 1'b0;
					if (expected_roots.size() == 0 && !out_valid) hold_off <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() == 0) begin
					in_valid <= 1'b0;
					stim_done <= 1'b1;
				end else begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// monitor: stall pattern of its own, compare each root transfer
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase % 1024 < 300) out_stall <= 1'b0;
			else out_stall <= ($urandom_range(0, 3) != 0);
			if (out_valid && !out_stall) begin
				if (expected_roots.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected root %h", out_data);
				end else if (out_data !== expected_roots[0]) begin
					errors++;
					if (errors <= 10)
						$display("root mismatch exp %h got %h", expected_roots[0], out_data);
					void'(expected_roots.pop_front());
				end else begin
					void'(expected_roots.pop_front());
				end
			end
		end
	end

	// reset, completion and timeout
	initial begin
		errors = 0;
		cycles = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stim_done && expected_roots.size() == 0) && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			repeat (300) @(posedge clk);
			if (errors == 0 && expected_roots.size() == 0)
				$display("Regression PASS");
			else
				$display("Regression FAIL");
			$finish;
		end
	end

endmodule
